@@ sv/dltq_pkg.sv @@
// Package for the delta list timer queue: table size, field codes, command and
// status structures shared by the controller and the datapath.
// Depends on nothing.
package dltq_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW          = $clog2(CAPACITY + 1);
    localparam int DEPTH       = 1 << AW;

    typedef logic [CW-1:0] t_idx;
    typedef logic [AW-1:0] t_addr;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic [2:0] EV_ADDED    = 3'd0;
    localparam logic [2:0] EV_FULL     = 3'd1;
    localparam logic [2:0] EV_REMOVED  = 3'd2;
    localparam logic [2:0] EV_NOTFOUND = 3'd3;
    localparam logic [2:0] EV_EXPIRED  = 3'd4;

    typedef logic [3:0] t_op;
    localparam t_op OP_NONE    = 4'd0;
    localparam t_op OP_ACCEPT  = 4'd1;
    localparam t_op OP_WALK    = 4'd2;
    localparam t_op OP_SHIFT   = 4'd3;
    localparam t_op OP_INSERT  = 4'd4;
    localparam t_op OP_SEARCH  = 4'd5;
    localparam t_op OP_HEAD    = 4'd6;
    localparam t_op OP_EXPIRE  = 4'd7;
    localparam t_op OP_COMPACT = 4'd8;
    localparam t_op OP_RESULT  = 4'd9;

    typedef struct packed {
        logic [31:0] delta;
        logic [31:0] packet;
        logic [15:0] port;
    } t_entry;

    typedef struct packed {
        t_op        op;
        logic [2:0] code;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic walk_go;
        logic no_shift;
        logic shift_last;
        logic srch_end;
        logic srch_hit;
        logic head_zero;
        logic exp_more;
        logic comp_end;
        logic out_free;
    } t_sts;

endpackage

@@ sv/dltq_if.sv @@
// Valid/ready channel interfaces for the request beats and the result beats.
// Depends on nothing.
interface dltq_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] duration;
    logic [31:0] packet;
    logic [15:0] port;

    modport source (output valid, kind, duration, packet, port, input ready);
    modport sink (input valid, kind, duration, packet, port, output ready);
endinterface

interface dltq_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [31:0] alert_packet;
    logic [15:0] alert_port;
    logic        last;

    modport source (output valid, event_res, alert_packet, alert_port, last, input ready);
    modport sink (input valid, event_res, alert_packet, alert_port, last, output ready);
endinterface

@@ sv/delta_list_timer_queue.sv @@
// Delta list timer queue, the top level: joins the controller and the datapath
// to the request and result channels. Depends on dltq_pkg, dltq_if, dltq_ctrl, dltq_dp.
// The block keeps up to sixteen retransmission timers in expiry order in an entry memory
// with one read and one write port and works on one request beat at a time, with ready
// low while busy. Every pass over the list moves one entry per cycle through that memory,
// but the expiry pass waits as long as the sink holds ready low. With n timers held, an
// add at position p walks to p, shifts the n - p later entries, inserts and answers; a
// remove searches to its match, compacts the later entries and answers; a tick counts
// the head down or sends its expiry beats and compacts. A tick on an empty table and an
// unknown kind give no beat. No clearing pass follows reset; the table starts empty.
module delta_list_timer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dltq_item_if.sink   i_item,
    dltq_res_if.source  o_res
);

    dltq_pkg::t_cmd cmd;
    dltq_pkg::t_sts sts;
    logic           in_ready;

    assign i_item.ready = in_ready;

    dltq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_kind  (i_item.kind),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dltq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_duration (i_item.duration),
        .i_packet   (i_item.packet),
        .i_port     (i_item.port),
        .o_res      (o_res)
    );

endmodule

@@ sv/dltq_ctrl.sv @@
// Controller state machine of the delta list timer queue: sequences walk, shift,
// search, expiry and compaction passes. Depends on dltq_pkg.
module dltq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_kind,
    output logic             o_in_ready,
    input  dltq_pkg::t_sts   i_sts,
    output dltq_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WALK    = 4'd1;
    localparam logic [3:0] S_SHIFT   = 4'd2;
    localparam logic [3:0] S_INSERT  = 4'd3;
    localparam logic [3:0] S_RESULT  = 4'd4;
    localparam logic [3:0] S_SEARCH  = 4'd5;
    localparam logic [3:0] S_HEAD    = 4'd6;
    localparam logic [3:0] S_EXPIRE  = 4'd7;
    localparam logic [3:0] S_COMPACT = 4'd8;

    logic [3:0] r_state, n_state;
    logic [2:0] r_code, n_code;
    logic [1:0] r_kind, n_kind;

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        n_kind     = r_kind;
        o_in_ready = 1'b0;
        o_cmd.op   = dltq_pkg::OP_NONE;
        o_cmd.code = r_code;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = dltq_pkg::OP_ACCEPT;
                    n_kind   = i_in_kind;
                    case (i_in_kind)
                        dltq_pkg::KIND_ADD: begin
                            if (i_sts.full) begin
                                n_code  = dltq_pkg::EV_FULL;
                                n_state = S_RESULT;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        dltq_pkg::KIND_REMOVE: n_state = S_SEARCH;
                        dltq_pkg::KIND_TICK: n_state = i_sts.empty ? S_IDLE : S_HEAD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.op = dltq_pkg::OP_WALK;
                if (!i_sts.walk_go) begin
                    n_state = i_sts.no_shift ? S_INSERT : S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.op = dltq_pkg::OP_SHIFT;
                if (i_sts.shift_last) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.op = dltq_pkg::OP_INSERT;
                n_code   = dltq_pkg::EV_ADDED;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                o_cmd.op = dltq_pkg::OP_RESULT;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                o_cmd.op = dltq_pkg::OP_SEARCH;
                if (i_sts.srch_end) begin
                    n_code  = dltq_pkg::EV_NOTFOUND;
                    n_state = S_RESULT;
                end else if (i_sts.srch_hit) begin
                    n_code  = dltq_pkg::EV_REMOVED;
                    n_state = S_COMPACT;
                end
            end
            S_HEAD: begin
                o_cmd.op = dltq_pkg::OP_HEAD;
                n_state  = i_sts.head_zero ? S_EXPIRE : S_IDLE;
            end
            S_EXPIRE: begin
                o_cmd.op = dltq_pkg::OP_EXPIRE;
                if (i_sts.out_free && !i_sts.exp_more) begin
                    n_state = S_COMPACT;
                end
            end
            S_COMPACT: begin
                o_cmd.op = dltq_pkg::OP_COMPACT;
                if (i_sts.comp_end) begin
                    n_state = (r_kind == dltq_pkg::KIND_REMOVE) ? S_RESULT : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_code <= n_code;
        r_kind <= n_kind;
    end

endmodule

@@ sv/dltq_dp.sv @@
// Datapath of the delta list timer queue: entry memory, walk counters, remaining
// duration and the result register. Depends on dltq_pkg and dltq_res_if.
module dltq_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dltq_pkg::t_cmd   i_cmd,
    output dltq_pkg::t_sts   o_sts,
    input  logic [31:0]      i_duration,
    input  logic [31:0]      i_packet,
    input  logic [15:0]      i_port,
    dltq_res_if.source       o_res
);

    dltq_pkg::t_entry mem [0:dltq_pkg::DEPTH-1];
    dltq_pkg::t_entry r_rdata;

    dltq_pkg::t_idx   r_idx, n_idx;
    dltq_pkg::t_idx   r_ptr, n_ptr;
    dltq_pkg::t_idx   r_count, n_count;
    logic [31:0]      r_dur, n_dur;
    logic [31:0]      r_carry, n_carry;
    logic [31:0]      r_pkt, n_pkt;
    logic [15:0]      r_port, n_port;
    logic [31:0]      r_pend_pkt, n_pend_pkt;
    logic [15:0]      r_pend_port, n_pend_port;

    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_out_code;
    logic [31:0]      r_out_pkt;
    logic [15:0]      r_out_port;
    logic             r_out_last;

    dltq_pkg::t_idx   rd_idx;
    logic             we;
    dltq_pkg::t_idx   wr_idx;
    dltq_pkg::t_entry wdata;
    logic             out_ld;
    logic [2:0]       out_code;
    logic [31:0]      out_pkt;
    logic [15:0]      out_port;
    logic             out_last;
    logic [31:0]      dec_delta;

    assign dec_delta = (r_rdata.delta != 32'd0) ? (r_rdata.delta - 32'd1) : 32'd0;

    assign o_sts.full       = (r_count == dltq_pkg::CW'(dltq_pkg::CAPACITY));
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.walk_go    = (r_idx < r_count) && (r_rdata.delta <= r_dur);
    assign o_sts.no_shift   = (r_idx == r_count);
    assign o_sts.shift_last = (r_ptr == r_idx);
    assign o_sts.srch_end   = (r_idx >= r_count);
    assign o_sts.srch_hit   = (r_idx < r_count) && (r_rdata.packet == r_pkt)
                              && (r_rdata.port == r_port);
    assign o_sts.head_zero  = (r_rdata.delta <= 32'd1);
    assign o_sts.exp_more   = (r_idx < r_count) && (32'(r_idx) < dltq_pkg::MAX_RESULTS)
                              && (r_rdata.delta == 32'd0);
    assign o_sts.comp_end   = (r_idx >= r_count);
    assign o_sts.out_free   = !r_out_valid || o_res.ready;

    always_comb begin
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_dur       = r_dur;
        n_carry     = r_carry;
        n_pkt       = r_pkt;
        n_port      = r_port;
        n_pend_pkt  = r_pend_pkt;
        n_pend_port = r_pend_port;
        rd_idx      = '0;
        we          = 1'b0;
        wr_idx      = '0;
        wdata       = r_rdata;
        out_ld      = 1'b0;
        out_code    = i_cmd.code;
        out_pkt     = r_pkt;
        out_port    = r_port;
        out_last    = 1'b1;
        case (i_cmd.op)
            dltq_pkg::OP_ACCEPT: begin
                n_dur   = i_duration;
                n_pkt   = i_packet;
                n_port  = i_port;
                n_idx   = '0;
                n_ptr   = '0;
                n_carry = 32'd0;
            end
            dltq_pkg::OP_WALK: begin
                if (o_sts.walk_go) begin
                    n_dur  = r_dur - r_rdata.delta;
                    n_idx  = r_idx + dltq_pkg::CW'(1);
                    rd_idx = r_idx + dltq_pkg::CW'(1);
                end else begin
                    n_ptr  = r_count - dltq_pkg::CW'(1);
                    rd_idx = r_count - dltq_pkg::CW'(1);
                end
            end
            dltq_pkg::OP_SHIFT: begin
                we     = 1'b1;
                wr_idx = r_ptr + dltq_pkg::CW'(1);
                if (o_sts.shift_last) begin
                    wdata.delta = r_rdata.delta - r_dur;
                end
                n_ptr  = r_ptr - dltq_pkg::CW'(1);
                rd_idx = r_ptr - dltq_pkg::CW'(1);
            end
            dltq_pkg::OP_INSERT: begin
                we           = 1'b1;
                wr_idx       = r_idx;
                wdata.delta  = r_dur;
                wdata.packet = r_pkt;
                wdata.port   = r_port;
                n_count      = r_count + dltq_pkg::CW'(1);
            end
            dltq_pkg::OP_SEARCH: begin
                rd_idx = r_idx + dltq_pkg::CW'(1);
                if (o_sts.srch_hit) begin
                    n_carry = r_rdata.delta;
                    n_ptr   = r_idx;
                    n_idx   = r_idx + dltq_pkg::CW'(1);
                end else if (!o_sts.srch_end) begin
                    n_idx = r_idx + dltq_pkg::CW'(1);
                end
            end
            dltq_pkg::OP_HEAD: begin
                if (o_sts.head_zero) begin
                    n_pend_pkt  = r_rdata.packet;
                    n_pend_port = r_rdata.port;
                    n_idx       = dltq_pkg::CW'(1);
                    n_ptr       = '0;
                    rd_idx      = dltq_pkg::CW'(1);
                end else begin
                    we          = 1'b1;
                    wr_idx      = '0;
                    wdata.delta = dec_delta;
                end
            end
            dltq_pkg::OP_EXPIRE: begin
                rd_idx = r_idx;
                if (o_sts.out_free) begin
                    out_ld   = 1'b1;
                    out_code = dltq_pkg::EV_EXPIRED;
                    out_pkt  = r_pend_pkt;
                    out_port = r_pend_port;
                    out_last = !o_sts.exp_more;
                    if (o_sts.exp_more) begin
                        n_pend_pkt  = r_rdata.packet;
                        n_pend_port = r_rdata.port;
                        n_idx       = r_idx + dltq_pkg::CW'(1);
                        rd_idx      = r_idx + dltq_pkg::CW'(1);
                    end
                end
            end
            dltq_pkg::OP_COMPACT: begin
                rd_idx = r_idx + dltq_pkg::CW'(1);
                if (o_sts.comp_end) begin
                    n_count = r_ptr;
                end else begin
                    we          = 1'b1;
                    wr_idx      = r_ptr;
                    wdata.delta = r_rdata.delta + r_carry;
                    n_carry     = 32'd0;
                    n_idx       = r_idx + dltq_pkg::CW'(1);
                    n_ptr       = r_ptr + dltq_pkg::CW'(1);
                end
            end
            dltq_pkg::OP_RESULT: begin
                out_ld = o_sts.out_free;
            end
            default: begin
                rd_idx = '0;
            end
        endcase
        n_out_valid = out_ld ? 1'b1 : (r_out_valid && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_idx[dltq_pkg::AW-1:0]] <= wdata;
        end
        r_rdata <= mem[rd_idx[dltq_pkg::AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_ptr       <= n_ptr;
        r_dur       <= n_dur;
        r_carry     <= n_carry;
        r_pkt       <= n_pkt;
        r_port      <= n_port;
        r_pend_pkt  <= n_pend_pkt;
        r_pend_port <= n_pend_port;
        if (out_ld) begin
            r_out_code <= out_code;
            r_out_pkt  <= out_pkt;
            r_out_port <= out_port;
            r_out_last <= out_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.event_res    = r_out_code;
    assign o_res.alert_packet = r_out_pkt;
    assign o_res.alert_port   = r_out_port;
    assign o_res.last         = r_out_last;

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ld |-> (!r_out_valid || o_res.ready))
        else $error("Result register loaded while a beat is still pending.");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == dltq_pkg::OP_INSERT) |-> (r_count < dltq_pkg::CW'(dltq_pkg::CAPACITY)))
        else $error("Insert issued on a full table.");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == dltq_pkg::OP_INSERT) |=> (r_count == $past(r_count) + dltq_pkg::CW'(1)))
        else $error("Entry count did not grow after an insert.");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == dltq_pkg::OP_COMPACT) |-> (r_ptr < r_idx))
        else $error("Compaction destination has caught up with its source.");

endmodule
